// ===== rtl/core/md5cc_pkg.sv =====
// Package for the container checksum engine: payload types, constants and MD5 tables.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
package md5cc_pkg;

  localparam int unsigned MAX_TOTAL_BYTES = 67108864;
  localparam int unsigned CNT_W = $clog2(MAX_TOTAL_BYTES + 1);
  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] SPLIT_TAIL = 6'd56;

  localparam logic [1:0] ST_VALID    = 2'd0;
  localparam logic [1:0] ST_MISMATCH = 2'd1;
  localparam logic [1:0] ST_ZERO     = 2'd2;
  localparam logic [1:0] ST_TOO_LONG = 2'd3;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [31:0] digest_a;
    logic [31:0] digest_b;
    logic [31:0] digest_c;
    logic [31:0] digest_d;
    logic [1:0]  check_status;
  } out_item_t;

  // Which block the datapath loads into the round unit.
  typedef enum logic [1:0] {
    BLK_DATA,
    BLK_SHORT,
    BLK_LONG_A,
    BLK_LONG_B
  } blk_sel_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic     take_byte;
    logic     drop_byte;
    logic     load_block;
    blk_sel_t sel;
    logic     round_step;
    logic     fold;
    logic     clear_block;
    logic     start_over;
  } dp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic       block_full;
    logic       can_take;
    logic       overflow;
    logic       split_tail;
    logic       rounds_done;
  } dp_stat_t;

  function automatic logic [31:0] sine_k(input logic [5:0] i);
    logic [31:0] k;
    case (i)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  function automatic logic [4:0] rot_amt(input logic [5:0] i);
    logic [4:0] s;
    case ({i[5:4], i[1:0]})
      4'd0: s = 5'd7;   4'd1: s = 5'd12; 4'd2: s = 5'd17; 4'd3: s = 5'd22;
      4'd4: s = 5'd5;   4'd5: s = 5'd9;  4'd6: s = 5'd14; 4'd7: s = 5'd20;
      4'd8: s = 5'd4;   4'd9: s = 5'd11; 4'd10: s = 5'd16; 4'd11: s = 5'd23;
      4'd12: s = 5'd6;  4'd13: s = 5'd10; 4'd14: s = 5'd15; default: s = 5'd21;
    endcase
    return s;
  endfunction

endpackage

// ===== rtl/core/md5cc_ctrl.sv =====
// Controller state machine of the container checksum engine.
// Depends on md5cc_pkg; drives the datapath through dp_cmd_t.
`timescale 1ns / 1ps
module md5cc_ctrl import md5cc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_last,
  input  logic     digest_zero,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd,
  output logic     res_load,
  output logic [1:0] res_kind,
  input  logic     res_busy
);

  typedef enum logic [2:0] {
    S_IDLE, S_ROUNDS, S_FIN_LOAD, S_FIN_ROUNDS, S_FIN2_LOAD, S_RESULT
  } state_t;

  state_t     state_r, state_nxt;
  logic       fin_r, fin_nxt;       // a finish follows the current block
  logic       second_r, second_nxt; // second finishing block pending

  assign in_ready = (state_r == S_IDLE) && !res_busy;

  always_comb begin
    logic acc;
    acc = in_valid && in_ready;
    state_nxt  = state_r;
    fin_nxt    = fin_r;
    second_nxt = second_r;
    cmd        = '0;
    cmd.sel    = BLK_DATA;
    res_load   = 1'b0;
    res_kind   = ST_VALID;
    unique case (state_r)
      S_IDLE: begin
        if (acc) begin
          cmd.take_byte = stat.can_take;
          cmd.drop_byte = !stat.can_take;
          fin_nxt = in_last;
          if (stat.can_take && stat.block_full) begin
            // Byte completes a block: compress it first.
            cmd.load_block = 1'b1;
            cmd.sel = BLK_DATA;
            state_nxt = S_ROUNDS;
          end else if (in_last) begin
            state_nxt = S_RESULT;
          end
        end
      end
      S_ROUNDS: begin
        cmd.round_step = 1'b1;
        if (stat.rounds_done) begin
          cmd.fold = 1'b1;
          cmd.clear_block = 1'b1;
          state_nxt = fin_r ? S_RESULT : S_IDLE;
        end
      end
      S_RESULT: begin
        // Decide between status shortcut and padding pass.
        if (digest_zero || stat.overflow) begin
          res_load = 1'b1;
          res_kind = digest_zero ? ST_ZERO : ST_TOO_LONG;
          cmd.start_over = 1'b1;
          fin_nxt = 1'b0;
          state_nxt = S_IDLE;
        end else begin
          cmd.load_block = 1'b1;
          cmd.sel = stat.split_tail ? BLK_LONG_A : BLK_SHORT;
          second_nxt = stat.split_tail;
          state_nxt = S_FIN_ROUNDS;
        end
      end
      S_FIN_ROUNDS: begin
        cmd.round_step = 1'b1;
        if (stat.rounds_done) begin
          cmd.fold = 1'b1;
          state_nxt = second_r ? S_FIN2_LOAD : S_FIN_LOAD;
        end
      end
      S_FIN2_LOAD: begin
        cmd.load_block = 1'b1;
        cmd.sel = BLK_LONG_B;
        second_nxt = 1'b0;
        state_nxt = S_FIN_ROUNDS;
      end
      S_FIN_LOAD: begin
        res_load = 1'b1;
        res_kind = ST_VALID;
        cmd.start_over = 1'b1;
        fin_nxt = 1'b0;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      fin_r    <= 1'b0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      fin_r    <= fin_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// ===== rtl/core/md5cc_datapath.sv =====
// Datapath of the container checksum engine: block buffer, byte count and MD5 round unit.
// Depends on md5cc_pkg; commanded by md5cc_ctrl.
`timescale 1ns / 1ps
module md5cc_datapath import md5cc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic [7:0]  data_byte,
  input  dp_cmd_t     cmd,
  output dp_stat_t    stat,
  output logic [127:0] hash
);

  logic [31:0]      blk_r [16];
  logic [31:0]      msg_r [16];
  logic [31:0]      h_r [4];
  logic [31:0]      a_r, b_r, c_r, d_r;
  logic [5:0]       rnd_r;
  logic [CNT_W-1:0] cnt_r;
  logic             ovf_r;

  logic [5:0]  tail;
  logic [31:0] bits;
  logic [31:0] len_word;

  assign tail     = cnt_r[5:0];
  assign bits     = 32'(cnt_r) << 3;
  assign len_word = (bits >> 2) | 32'd1;

  assign stat.block_full  = (tail == 6'd63);
  assign stat.can_take    = !ovf_r && (cnt_r < CNT_W'(MAX_TOTAL_BYTES));
  assign stat.overflow    = ovf_r;
  assign stat.split_tail  = (tail >= SPLIT_TAIL);
  assign stat.rounds_done = (rnd_r == 6'd63);

  assign hash = {h_r[0], h_r[1], h_r[2], h_r[3]};

  // Byte of the buffered tail at a given position.
  function automatic logic [7:0] tail_byte(input logic [31:0] w [16], input logic [5:0] p);
    logic [31:0] word;
    word = w[p[5:2]];
    return word[8*p[1:0] +: 8];
  endfunction

  // One MD5 round.
  logic [31:0] f, g_word, sum, rot, b_new;
  logic [3:0]  g;
  always_comb begin
    unique case (rnd_r[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = rnd_r[3:0]; end
      2'd1: begin f = (d_r & b_r) | (~d_r & c_r); g = 4'(5 * rnd_r + 1); end
      2'd2: begin f = b_r ^ c_r ^ d_r; g = 4'(3 * rnd_r + 5); end
      default: begin f = c_r ^ (b_r | ~d_r); g = 4'(7 * rnd_r); end
    endcase
    g_word = msg_r[g];
    sum    = a_r + f + sine_k(rnd_r) + g_word;
    rot    = (sum << rot_amt(rnd_r)) | (sum >> (6'd32 - {1'b0, rot_amt(rnd_r)}));
    b_new  = b_r + rot;
  end

  // Message block to be compressed next.
  logic [31:0] load_w [16];
  always_comb begin
    logic [5:0] pos;
    for (int i = 0; i < 16; i++) load_w[i] = 32'd0;
    unique case (cmd.sel)
      BLK_DATA: begin
        for (int i = 0; i < 16; i++) load_w[i] = blk_r[i];
        load_w[15][31:24] = data_byte;
      end
      BLK_LONG_A: begin
        for (int i = 0; i < 16; i++) load_w[i] = blk_r[i];
        load_w[tail[5:2]][8*tail[1:0] +: 8] = PAD_MARK;
      end
      BLK_LONG_B: begin
        load_w[0]  = bits;
        load_w[15] = len_word;
      end
      default: begin
        // Short tail: length word, tail bytes shifted by four, marker.
        load_w[0] = bits;
        for (int p = 0; p < 56; p++) begin
          pos = 6'(p);
          if (pos < tail)
            load_w[(p + 4) / 4][8*((p + 4) % 4) +: 8] = tail_byte(blk_r, pos);
          else if (pos == tail)
            load_w[(p + 4) / 4][8*((p + 4) % 4) +: 8] = PAD_MARK;
        end
        load_w[15] = len_word;
      end
    endcase
  end

  // Byte buffer and count.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 16; i++) blk_r[i] <= 32'd0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else if (cmd.start_over) begin
      for (int i = 0; i < 16; i++) blk_r[i] <= 32'd0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
    end else begin
      if (cmd.take_byte) begin
        blk_r[tail[5:2]][8*tail[1:0] +: 8] <= data_byte;
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.drop_byte) ovf_r <= 1'b1;
      if (cmd.clear_block)
        for (int i = 0; i < 16; i++) blk_r[i] <= 32'd0;
    end
  end

  // Round unit and chaining state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      h_r[0] <= 32'h67452301; h_r[1] <= 32'hefcdab89;
      h_r[2] <= 32'h98badcfe; h_r[3] <= 32'h10325476;
      rnd_r  <= 6'd0;
    end else begin
      if (cmd.load_block) begin
        for (int i = 0; i < 16; i++) msg_r[i] <= load_w[i];
        a_r <= h_r[0]; b_r <= h_r[1]; c_r <= h_r[2]; d_r <= h_r[3];
        rnd_r <= 6'd0;
      end else if (cmd.round_step) begin
        a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_new;
        rnd_r <= rnd_r + 6'd1;
      end
      if (cmd.fold) begin
        h_r[0] <= h_r[0] + d_r;
        h_r[1] <= h_r[1] + b_new;
        h_r[2] <= h_r[2] + b_r;
        h_r[3] <= h_r[3] + c_r;
      end
      if (cmd.start_over) begin
        h_r[0] <= 32'h67452301; h_r[1] <= 32'hefcdab89;
        h_r[2] <= 32'h98badcfe; h_r[3] <= 32'h10325476;
      end
    end
  end

endmodule

// ===== rtl/core/md5_checksum_custom_padding.sv =====
// A byte that completes a block is compressed by the single MD5 round unit, which does
// one of 64 rounds per cycle; no new byte is taken meanwhile.
// The last byte gives a status result for a zero stored digest or an overflow, else its
// result follows one or two finishing blocks (and its own block, if it completes one).
// Throughput: one byte per cycle, stalled while a block is hashed or a result waits.
// Reset: synchronous, active low; clears the chaining state, count and stored-digest registers.
`timescale 1ns / 1ps
module md5_checksum_custom_padding import md5cc_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [3:0]  cfg_paddr,
  input  logic [63:0] cfg_pwdata,
  output logic [63:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic [3:0] REG_LOW  = 4'h0;
  localparam logic [3:0] REG_HIGH = 4'h8;

  logic [63:0] exp_lo_r, exp_hi_r;
  logic        out_valid_r;
  out_item_t   out_r;
  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [127:0] hash;
  logic        res_load;
  logic [1:0]  res_kind;
  logic        digest_zero;

  assign cfg_pready  = 1'b1;
  assign digest_zero = (exp_lo_r == 64'd0) && (exp_hi_r == 64'd0);

  // Configuration writes and read-back.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_lo_r <= 64'd0;
      exp_hi_r <= 64'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite) begin
      unique case (cfg_paddr)
        REG_LOW:  exp_lo_r <= cfg_pwdata;
        REG_HIGH: exp_hi_r <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr)
      REG_LOW:  cfg_prdata = exp_lo_r;
      REG_HIGH: cfg_prdata = exp_hi_r;
      default:  cfg_prdata = 64'd0;
    endcase
  end

  md5cc_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_last(in_data.last_byte), .digest_zero, .stat, .cmd,
    .res_load, .res_kind, .res_busy(out_valid_r)
  );

  md5cc_datapath u_dp (
    .clk, .rst_n, .data_byte(in_data.data_byte), .cmd, .stat, .hash
  );

  // Result register: the status compares the chaining state with the stored digest.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      if (res_load) begin
        out_valid_r <= 1'b1;
        if (res_kind != ST_VALID) begin
          out_r <= '{32'd0, 32'd0, 32'd0, 32'd0, res_kind};
        end else begin
          out_r.digest_a <= hash[127:96];
          out_r.digest_b <= hash[95:64];
          out_r.digest_c <= hash[63:32];
          out_r.digest_d <= hash[31:0];
          out_r.check_status <= ({hash[95:64], hash[127:96]} == exp_lo_r &&
                                 {hash[31:0], hash[63:32]} == exp_hi_r)
                                ? ST_VALID : ST_MISMATCH;
        end
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef NO_ASSERTIONS
  // No new byte is taken while a result waits.
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !in_ready) else $error("byte taken while result pending");
  // A zero-digest status result reports a zeroed first digest word.
  a_zero_words: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.check_status == ST_ZERO) |-> (out_data.digest_a == 32'd0))
    else $error("zero-digest result carries data");
  // A result is loaded only when the output register is free.
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> !out_valid_r) else $error("result overwritten");
`endif

endmodule
